>>> src/swm_pkg.sv
// Shared types and constants for the sliding-window median filter.
// Used by the channel interfaces, the sorter cell, the output buffer and the top level.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

  localparam int SWM_WINDOW = 99;
  localparam int SAMPLE_W   = 16;
  localparam int RESULT_W   = 17;

  typedef enum logic [1:0] {
    KIND_LO,
    KIND_VAL,
    KIND_HI
  } kind_t;

  typedef struct packed {
    logic gt;
    logic eb;
    logic del;
  } cell_flags_t;

  typedef struct packed {
    logic full;
    logic fill_lo;
  } chain_ctrl_t;

endpackage

`default_nettype wire

>>> src/swm_sample_if.sv
// Input channel of the median filter: one signed sensor sample per word.
// Depends on swm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface swm_sample_if import swm_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

>>> src/swm_median_if.sv
// Output channel of the median filter: twice the window median per word.
// Depends on swm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface swm_median_if import swm_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] median_times_two;

  modport source (output valid, output median_times_two, input ready);
  modport sink   (input valid, input median_times_two, output ready);
endinterface

`default_nettype wire

>>> src/swm_cell.sv
// One cell of the sorted chain: holds a sample (or a low/high pad) and its ring tag,
// and each update takes its own, a neighbor's or the new sample. Depends on swm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swm_cell import swm_pkg::*; #(
  parameter int    TAG_W    = 7,
  parameter bit    IS_FIRST = 1'b0,
  parameter bit    IS_LAST  = 1'b0,
  parameter kind_t RST_KIND = KIND_HI
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       shift,
  input  wire chain_ctrl_t                ctrl,
  input  wire logic signed [SAMPLE_W-1:0] x,
  input  wire logic [TAG_W-1:0]           x_tag,
  input  wire logic signed [SAMPLE_W-1:0] evict_val,
  input  wire logic [TAG_W-1:0]           evict_tag,
  input  wire kind_t                      prev_kind,
  input  wire logic signed [SAMPLE_W-1:0] prev_val,
  input  wire logic [TAG_W-1:0]           prev_tag,
  input  wire cell_flags_t                prev_flags,
  input  wire kind_t                      next_kind,
  input  wire logic signed [SAMPLE_W-1:0] next_val,
  input  wire logic [TAG_W-1:0]           next_tag,
  input  wire cell_flags_t                next_flags,
  output kind_t                           kind,
  output logic signed [SAMPLE_W-1:0]      val,
  output logic [TAG_W-1:0]                tag,
  output cell_flags_t                     flags,
  output logic signed [SAMPLE_W-1:0]      val_next
);

  kind_t            kind_next;
  logic [TAG_W-1:0] tag_next;

  always_comb begin
    flags.gt  = (kind == KIND_HI) || ((kind == KIND_VAL) && (val > x));
    if (ctrl.full) begin
      flags.del = (kind == KIND_VAL) && (tag == evict_tag);
      flags.eb  = (kind == KIND_VAL) && !flags.del && (evict_val <= val);
    end else begin
      flags.del = ctrl.fill_lo ? IS_FIRST : IS_LAST;
      flags.eb  = ctrl.fill_lo && !IS_FIRST;
    end
  end

  // hold, take from the right, take from the left, or take the new sample
  always_comb begin
    if (!flags.del && (flags.gt == flags.eb)) begin
      kind_next = kind;
      val_next  = val;
      tag_next  = tag;
    end else if (!next_flags.del && !next_flags.gt && next_flags.eb) begin
      kind_next = next_kind;
      val_next  = next_val;
      tag_next  = next_tag;
    end else if (!prev_flags.del && prev_flags.gt && !prev_flags.eb) begin
      kind_next = prev_kind;
      val_next  = prev_val;
      tag_next  = prev_tag;
    end else begin
      kind_next = KIND_VAL;
      val_next  = x;
      tag_next  = x_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= RST_KIND;
    end else if (shift) begin
      kind <= kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      val <= val_next;
      tag <= tag_next;
    end
  end

endmodule

`default_nettype wire

>>> src/swm_outbuf.sv
// Two-word output buffer that decouples the sorter from a stalled receiver.
// Depends on swm_pkg and swm_median_if.
`timescale 1ns / 1ps
`default_nettype none

module swm_outbuf import swm_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic signed [RESULT_W-1:0] push_data,
  output logic                            room,
  swm_median_if.source                    medians
);

  logic                       head_valid;
  logic                       tail_valid;
  logic signed [RESULT_W-1:0] head_data;
  logic signed [RESULT_W-1:0] tail_data;
  logic                       pop;

  assign room                     = !tail_valid;
  assign pop                      = head_valid && medians.ready;
  assign medians.valid            = head_valid;
  assign medians.median_times_two = head_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else begin
      if (pop) begin
        head_valid <= tail_valid || push;
        tail_valid <= 1'b0;
      end else if (push) begin
        head_valid <= 1'b1;
        tail_valid <= head_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      head_data <= tail_valid ? tail_data : push_data;
    end else if (push && !head_valid) begin
      head_data <= push_data;
    end
    if (push && head_valid && !pop) begin
      tail_data <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_tail_needs_head: assert property (@(posedge clk) disable iff (rst)
    tail_valid |-> head_valid)
    else $error("second buffer word held without a first");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    (head_valid && tail_valid && !medians.ready) |=> (head_valid && tail_valid))
    else $error("buffered word lost while stalled");
`endif

endmodule

`default_nettype wire

>>> src/sliding_window_median.sv
// Top level of the sliding-window median filter: sorted cell chain, sample delay line,
// ring position counter and output buffer. Depends on swm_pkg, both interfaces,
// swm_cell and swm_outbuf.
//
// Usage:
//   samples  (sink)   - one signed 16-bit sample per word, taken when valid and ready.
//   medians  (source) - one word per sample: twice the median of the last WINDOW
//                       samples (of all samples so far until WINDOW have arrived).
//   Output: each result is registered in the output buffer before it is offered.
//   Throughput: one sample per cycle while the output buffer has room; each word moves
//   every cell of the chain one step (evict the oldest sample, insert the new one).
//   Reset (rst, synchronous): empties the window; the chain holds low and high
//   pads and the next sample starts a new fill. No clearing pass is needed.
//   Stall: a two-word output buffer keeps taking samples while one result waits;
//   with two results waiting, samples.ready drops until medians.ready returns.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median import swm_pkg::*; #(
  parameter int WINDOW = SWM_WINDOW
) (
  input  wire logic  clk,
  input  wire logic  rst,
  swm_sample_if.sink samples,
  swm_median_if.source medians
);

  localparam int TAG_W   = $clog2(WINDOW);
  localparam int MID     = WINDOW / 2;
  localparam bit WIN_ODD = (WINDOW % 2) == 1;

  logic                       accept;
  logic                       room;
  logic [TAG_W-1:0]           wp;
  logic                       full;
  chain_ctrl_t                ctrl;
  logic signed [SAMPLE_W-1:0] ring [WINDOW];
  logic                       odd;
  logic signed [RESULT_W-1:0] result;

  kind_t                      kind     [WINDOW];
  logic signed [SAMPLE_W-1:0] val      [WINDOW];
  logic [TAG_W-1:0]           tag      [WINDOW];
  cell_flags_t                flags    [WINDOW];
  logic signed [SAMPLE_W-1:0] val_next [WINDOW];
  logic [WINDOW-1:0]          del_vec;
  logic [WINDOW-1:0]          is_val;

  assign samples.ready = room;
  assign accept        = samples.valid && room;
  assign ctrl.full     = full;
  assign ctrl.fill_lo  = wp[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      full <= 1'b0;
    end else if (accept) begin
      if (wp == TAG_W'(WINDOW - 1)) begin
        wp   <= '0;
        full <= 1'b1;
      end else begin
        wp <= wp + 1'b1;
      end
    end
  end

  // advance the delay line; its last tap is the sample about to leave the window
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[0] <= samples.sample;
      for (int k = 1; k < WINDOW; k++) begin
        ring[k] <= ring[k-1];
      end
    end
  end

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    kind_t                      pk;
    logic signed [SAMPLE_W-1:0] pv;
    logic [TAG_W-1:0]           pt;
    cell_flags_t                pf;
    kind_t                      nk;
    logic signed [SAMPLE_W-1:0] nv;
    logic [TAG_W-1:0]           nt;
    cell_flags_t                nf;

    if (i == 0) begin : g_first
      assign pk = KIND_LO;
      assign pv = '0;
      assign pt = '0;
      assign pf = '{gt: 1'b0, eb: 1'b0, del: 1'b1};
    end else begin : g_prev
      assign pk = kind[i-1];
      assign pv = val[i-1];
      assign pt = tag[i-1];
      assign pf = flags[i-1];
    end

    if (i == WINDOW - 1) begin : g_last
      assign nk = KIND_HI;
      assign nv = '0;
      assign nt = '0;
      assign nf = '{gt: 1'b0, eb: 1'b0, del: 1'b1};
    end else begin : g_next
      assign nk = kind[i+1];
      assign nv = val[i+1];
      assign nt = tag[i+1];
      assign nf = flags[i+1];
    end

    swm_cell #(
      .TAG_W    (TAG_W),
      .IS_FIRST (i == 0),
      .IS_LAST  (i == WINDOW - 1),
      .RST_KIND ((i < MID) ? KIND_LO : KIND_HI)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (accept),
      .ctrl       (ctrl),
      .x          (samples.sample),
      .x_tag      (wp),
      .evict_val  (ring[WINDOW-1]),
      .evict_tag  (wp),
      .prev_kind  (pk),
      .prev_val   (pv),
      .prev_tag   (pt),
      .prev_flags (pf),
      .next_kind  (nk),
      .next_val   (nv),
      .next_tag   (nt),
      .next_flags (nf),
      .kind       (kind[i]),
      .val        (val[i]),
      .tag        (tag[i]),
      .flags      (flags[i]),
      .val_next   (val_next[i])
    );

    assign del_vec[i] = flags[i].del;
    assign is_val[i]  = (kind[i] == KIND_VAL);
  end

  // the pads keep the central values at fixed cells during the fill
  assign odd = full ? WIN_ODD : !wp[0];

  always_comb begin
    if (odd) begin
      result = {val_next[MID], 1'b0};
    end else begin
      result = RESULT_W'($signed({val_next[MID-1][SAMPLE_W-1], val_next[MID-1]}) +
                         $signed({val_next[MID][SAMPLE_W-1], val_next[MID]}));
    end
  end

  swm_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .room      (room),
    .medians   (medians)
  );

`ifndef NO_ASSERTIONS
  a_one_eviction: assert property (@(posedge clk) disable iff (rst)
    (accept && full) |-> $onehot(del_vec))
    else $error("full window must evict exactly one cell");

  a_no_pads_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> (&is_val))
    else $error("pad cell left in a full window");

  a_wp_in_range: assert property (@(posedge clk) disable iff (rst)
    wp <= TAG_W'(WINDOW - 1))
    else $error("ring position out of range");

  a_result_offered: assert property (@(posedge clk) disable iff (rst)
    accept |=> medians.valid)
    else $error("accepted sample produced no result word");
`endif

endmodule

`default_nettype wire
